>>> design/tst_pkg.sv
// shared constants, types and helper functions for the tune serialiser
`default_nettype none

package tst_pkg;

    localparam int FREQ_W      = 13;
    localparam int WORD_W      = 16;
    localparam int FRAME_BITS  = 25;
    localparam int POS_W       = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] FREQ_BASE_MHZ = 16'd479;
    localparam logic [POS_W-1:0]  POS_LAST      = POS_W'(FRAME_BITS - 1);
    localparam logic [POS_W-1:0]  POS_RST_ADDR  = 5'd3;
    localparam logic [POS_W-1:0]  POS_CH_ADDR   = 5'd0;
    localparam logic [POS_W-1:0]  POS_WRITE     = 5'd4;
    localparam logic [POS_W-1:0]  POS_WORD_LO   = 5'd5;
    localparam logic [POS_W-1:0]  POS_WORD_END  = POS_W'(5 + WORD_W);

    localparam logic FUNC_FREQ = 1'b0;
    localparam logic FUNC_WORD = 1'b1;

    localparam logic FRAME_RESET   = 1'b0;
    localparam logic FRAME_CHANNEL = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // word = ((t / 32) << 7) + t % 32 with t = (f - base) / 2, kept to 16 bits
    function automatic word_t word_from_freq(input logic [FREQ_W-1:0] freq);
        logic [WORD_W-1:0] diff;
        begin
            diff = {{(WORD_W-FREQ_W){1'b0}}, freq} - FREQ_BASE_MHZ;
            return {diff[14:6], 2'b00, diff[5:1]};
        end
    endfunction

    function automatic logic frame_bit(input logic frame, input logic [POS_W-1:0] pos,
                                       input word_t word);
        logic [POS_W-1:0] idx;
        begin
            idx = pos - POS_WORD_LO;
            if (frame == FRAME_RESET)
                return (pos == POS_RST_ADDR);
            else if (pos == POS_CH_ADDR || pos == POS_WRITE)
                return 1'b1;
            else if (pos >= POS_WORD_LO && pos < POS_WORD_END)
                return word[idx[$clog2(WORD_W)-1:0]];
            else
                return 1'b0;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/synth_tune_serializer_unit.sv
// top level of the synthesiser tune serialiser
// first bit valid after the queue, the back-end word register and the output register
// one serial bit per cycle from the back-end shifter unless out_ready holds the output
// a two-entry word queue lets the front accept while the back is still shifting
// reset: asynchronous, active low; queue emptied, shifter idle, no output valid
`default_nettype none

module synth_tune_serializer_unit
    import tst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [FREQ_W-1:0] freq_mhz,
    input  wire logic [WORD_W-1:0] reg_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   data_bit,
    output logic                   frame_index,
    output logic [POS_W-1:0]       bit_index,
    output logic                   latch,
    output logic                   last
);

    q_status_t q_status;
    logic      push, pop;
    word_t     push_word, head;

    tst_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .freq_mhz  (freq_mhz),
        .reg_word  (reg_word),
        .q_status  (q_status),
        .push      (push),
        .push_word (push_word)
    );

    tst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    tst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_bit    (data_bit),
        .frame_index (frame_index),
        .bit_index   (bit_index),
        .latch       (latch),
        .last        (last)
    );

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_index && latch && bit_index == POS_LAST)
        else $error("last flag away from end of channel frame");

    a_frame_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && latch && !frame_index
        |=> out_valid && frame_index && bit_index == '0)
        else $error("channel frame does not follow reset frame");

    a_reset_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_index |-> data_bit == (bit_index == POS_RST_ADDR))
        else $error("reset frame bit wrong");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> design/tst_front.sv
// front end: accepts requests and turns them into synthesiser words
`default_nettype none

module tst_front
    import tst_pkg::*;
(
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [FREQ_W-1:0] freq_mhz,
    input  wire word_t             reg_word,
    input  wire q_status_t         q_status,
    output logic                   push,
    output word_t                  push_word
);

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        unique case (func)
            FUNC_FREQ: push_word = word_from_freq(freq_mhz);
            FUNC_WORD: push_word = reg_word;
            default:   push_word = reg_word;
        endcase
    end

endmodule

`default_nettype wire

>>> design/tst_queue.sv
// short word queue between front and back ends
`default_nettype none

module tst_queue
    import tst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire word_t push_word,
    input  wire logic  pop,
    output word_t      head,
    output q_status_t  status
);

    word_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

>>> design/tst_back.sv
// back end: shifts out the reset frame and the channel frame for each word
`default_nettype none

module tst_back
    import tst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire q_status_t  q_status,
    input  wire word_t      head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            data_bit,
    output logic            frame_index,
    output logic [POS_W-1:0] bit_index,
    output logic            latch,
    output logic            last
);

    logic             busy_reg, busy_next;
    word_t            word_reg;
    logic             frame_reg;
    logic [POS_W-1:0] pos_reg;
    logic             ov_reg, ov_next;
    logic             data_reg, frm_out_reg, latch_reg, last_reg;
    logic [POS_W-1:0] idx_out_reg;

    logic load, emit, pos_end, end_item;

    assign load     = !ov_reg || out_ready;
    assign emit     = load && busy_reg;
    assign pos_end  = (pos_reg == POS_LAST);
    assign end_item = emit && (frame_reg == FRAME_CHANNEL) && pos_end;
    assign pop      = !q_status.empty && (!busy_reg || end_item);

    always_comb
    begin
        busy_next = busy_reg;
        if (pop)
            busy_next = 1'b1;
        else if (end_item)
            busy_next = 1'b0;

        ov_next = ov_reg;
        if (emit)
            ov_next = 1'b1;
        else if (load)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    // word and bit position
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg  <= head;
            frame_reg <= FRAME_RESET;
            pos_reg   <= '0;
        end
        else if (emit)
        begin
            if (pos_end)
            begin
                pos_reg   <= '0;
                frame_reg <= FRAME_CHANNEL;
            end
            else
                pos_reg <= pos_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg    <= frame_bit(frame_reg, pos_reg, word_reg);
            frm_out_reg <= frame_reg;
            idx_out_reg <= pos_reg;
            latch_reg   <= pos_end;
            last_reg    <= pos_end && (frame_reg == FRAME_CHANNEL);
        end
    end

    assign out_valid   = ov_reg;
    assign data_bit    = data_reg;
    assign frame_index = frm_out_reg;
    assign bit_index   = idx_out_reg;
    assign latch       = latch_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
